@@ sv/block_decomposition_address_generator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// block decomposition address generator: assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef BLOCK_DECOMPOSITION_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define BLOCK_DECOMPOSITION_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BDAG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bdag check failed");

// next-cycle implication
`define BDAG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bdag check failed");

`endif

@@ sv/bdag_pkg.sv @@
// ----------------------------------------------------------------------------
// bdag_pkg
// shared types and constants of the block decomposition address generator
// ----------------------------------------------------------------------------
package bdag_pkg;

	localparam int ADDR_W    = 40;
	localparam int RANK_W    = 24;
	localparam int SIZE_W    = 13;
	localparam int PROCS_W   = 9;
	localparam int DIMS_W    = 2;
	localparam int VARS_W    = 5;
	localparam int VIDX_W    = 4;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int NDIM      = 3;
	localparam int MUL_B_W   = 13;
	localparam int DIV_N_W   = 24;
	localparam int DIV_D_W   = 13;
	localparam logic [VARS_W-1:0] VARS_CAP = 5'd16;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_RANK = 2'd1,
		ST_NO_BLOCK = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_DIMS  = 3'd0,
		CFG_SIZE0     = 3'd1,
		CFG_SIZE1     = 3'd2,
		CFG_SIZE2     = 3'd3,
		CFG_PROCS0    = 3'd4,
		CFG_PROCS1    = 3'd5,
		CFG_PROCS2    = 3'd6,
		CFG_NUM_VARS  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              kind;
		logic [RANK_W-1:0] rank;
	} in_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] global_address;
		logic [ADDR_W-1:0] local_address;
		logic              last_word;
		status_t           status;
	} out_req_t;

endpackage

@@ sv/bdag_stream_if.sv @@
// ----------------------------------------------------------------------------
// bdag_stream_if
// valid/ready request channel carrying one payload
// ----------------------------------------------------------------------------
interface bdag_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/block_decomposition_address_generator_unit.sv @@
// step request: three 13-bit serial multiplies, then the result passes through res_q into
//   the output register; the next request is taken once S_RES has handed the result on
// start request: six 24-bit serial divides and three start multiplies before the result;
//   bad rank after the three rank divides, a step with no block goes straight to S_RES
// one request at a time; a result stalled at the output holds off the next request
// arst_n clears configuration to defaults and leaves no block active
// ----------------------------------------------------------------------------
// block_decomposition_address_generator_unit
// per-rank sub-block selection and global/local word address walk
// ----------------------------------------------------------------------------
module block_decomposition_address_generator_unit import bdag_pkg::*; #(
	parameter int MAX_DIMS          = 3,
	parameter int MAX_EXTENT        = 4096,
	parameter int MAX_PROCS_PER_DIM = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bdag_stream_if.sink          in_req,
	bdag_stream_if.source        out_req
);
	localparam logic [DIMS_W-1:0]  DIMS_CAP  = DIMS_W'(MAX_DIMS);
	localparam logic [SIZE_W-1:0]  EXT_CAP   =
		(MAX_EXTENT > 8191) ? 13'h1fff : SIZE_W'(MAX_EXTENT);
	localparam logic [PROCS_W-1:0] PROCS_CAP =
		(MAX_PROCS_PER_DIM > 511) ? 9'h1ff : PROCS_W'(MAX_PROCS_PER_DIM);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDIV = 6'b000010,
		S_SDIV = 6'b000100,
		S_SMUL = 6'b001000,
		S_HMUL = 6'b010000,
		S_RES  = 6'b100000
	} state_t;

	state_t state_q;

	logic [DIMS_W-1:0]  num_dims_q;
	logic [SIZE_W-1:0]  size_q [NDIM];
	logic [PROCS_W-1:0] procs_q [NDIM];
	logic [VARS_W-1:0]  num_vars_q;

	logic [SIZE_W-1:0]  start_q [NDIM];
	logic [SIZE_W-1:0]  len_q [NDIM];
	logic [SIZE_W-1:0]  walk_q [NDIM];
	logic [VIDX_W-1:0]  var_q;
	logic               active_q;

	logic [PROCS_W-1:0] coord_q [NDIM];
	logic [SIZE_W-1:0]  share_q;
	logic [SIZE_W-1:0]  srem_q;
	logic               empty_q;
	logic [1:0]         d_q;
	logic [1:0]         h_q;

	logic               div_go_q;
	logic [DIV_N_W-1:0] div_n_q;
	logic [DIV_D_W-1:0] div_d_q;
	logic               mul_go_q;
	logic [ADDR_W-1:0]  mg_a_q;
	logic [MUL_B_W-1:0] mg_b_q;
	logic [ADDR_W-1:0]  ml_a_q;
	logic [MUL_B_W-1:0] ml_b_q;

	out_req_t           res_q;
	out_req_t           out_data_q;
	logic               out_valid_q;

	logic               div_done;
	logic [DIV_N_W-1:0] div_quot;
	logic [DIV_D_W-1:0] div_rem;
	logic               mg_done;
	logic [ADDR_W-1:0]  mg_prod;
	logic               ml_done;
	logic [ADDR_W-1:0]  ml_prod;

	logic [DIMS_W-1:0]  dims_used;
	logic [SIZE_W-1:0]  size_eff [NDIM];
	logic [PROCS_W-1:0] procs_eff [NDIM];
	logic [VARS_W-1:0]  nv_eff;
	logic [SIZE_W:0]    gsum [NDIM];
	logic [NDIM-1:0]    inc;
	logic               at_end;
	logic [1:0]         dn;
	logic [ADDR_W-1:0]  add_g;
	logic [ADDR_W-1:0]  add_l;
	logic [MUL_B_W-1:0] nmul_g;
	logic [MUL_B_W-1:0] nmul_l;
	logic [ADDR_W-1:0]  sum_g;
	logic [ADDR_W-1:0]  sum_l;
	logic [SIZE_W-1:0]  len_new;
	logic               empty_n;
	logic               in_fire;

	bdag_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .dividend(div_n_q),
		.divisor(div_d_q), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	bdag_mul u_mul_g (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mg_a_q), .b(mg_b_q),
		.done(mg_done), .prod(mg_prod)
	);

	bdag_mul u_mul_l (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(ml_a_q), .b(ml_b_q),
		.done(ml_done), .prod(ml_prod)
	);

	always_comb begin
		if (num_dims_q == '0) begin
			dims_used = DIMS_W'(1);
		end else if (num_dims_q > DIMS_CAP) begin
			dims_used = DIMS_CAP;
		end else begin
			dims_used = num_dims_q;
		end
		for (int d = 0; d < NDIM; d++) begin
			if (DIMS_W'(d) >= dims_used) begin
				size_eff[d]  = SIZE_W'(1);
				procs_eff[d] = PROCS_W'(1);
			end else begin
				if (size_q[d] == '0) size_eff[d] = SIZE_W'(1);
				else if (size_q[d] > EXT_CAP) size_eff[d] = EXT_CAP;
				else size_eff[d] = size_q[d];
				if (procs_q[d] == '0) procs_eff[d] = PROCS_W'(1);
				else if (procs_q[d] > PROCS_CAP) procs_eff[d] = PROCS_CAP;
				else procs_eff[d] = procs_q[d];
			end
			gsum[d] = {1'b0, walk_q[d]} + {1'b0, start_q[d]};
			inc[d]  = ({1'b0, walk_q[d]} + 1'b1) < {1'b0, len_q[d]};
		end
		if (num_vars_q == '0) nv_eff = VARS_W'(1);
		else if (num_vars_q > VARS_CAP) nv_eff = VARS_CAP;
		else nv_eff = num_vars_q;
		at_end = ({1'b0, var_q} >= nv_eff - 1'b1) && (inc == '0);
		dn = d_q + 2'd1;
	end

	// horner terms for the current step of the address walk
	always_comb begin
		unique case (h_q)
			2'd2: begin
				add_g  = ADDR_W'(gsum[1]);
				add_l  = ADDR_W'(walk_q[1]);
				nmul_g = MUL_B_W'(size_eff[0]);
				nmul_l = MUL_B_W'(len_q[0]);
			end
			2'd1: begin
				add_g  = ADDR_W'(gsum[0]);
				add_l  = ADDR_W'(walk_q[0]);
				nmul_g = MUL_B_W'(nv_eff);
				nmul_l = MUL_B_W'(nv_eff);
			end
			default: begin
				add_g  = ADDR_W'(var_q);
				add_l  = ADDR_W'(var_q);
				nmul_g = '0;
				nmul_l = '0;
			end
		endcase
		sum_g   = mg_prod + add_g;
		sum_l   = ml_prod + add_l;
		len_new = (coord_q[d_q] == procs_eff[d_q] - 1'b1) ? share_q + srem_q : share_q;
		empty_n = empty_q | (len_new == '0);
	end

	assign in_fire       = in_req.valid && in_req.ready;
	assign in_req.ready  = (state_q == S_IDLE);
	assign out_req.valid = out_valid_q;
	assign out_req.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_dims_q  <= DIMS_W'(1);
			num_vars_q  <= VARS_W'(1);
			for (int d = 0; d < NDIM; d++) begin
				size_q[d]  <= SIZE_W'(1);
				procs_q[d] <= PROCS_W'(1);
				start_q[d] <= '0;
				len_q[d]   <= '0;
				walk_q[d]  <= '0;
				coord_q[d] <= '0;
			end
			var_q       <= '0;
			active_q    <= 1'b0;
			share_q     <= '0;
			srem_q      <= '0;
			empty_q     <= 1'b0;
			d_q         <= '0;
			h_q         <= '0;
			div_go_q    <= 1'b0;
			div_n_q     <= '0;
			div_d_q     <= '0;
			mul_go_q    <= 1'b0;
			mg_a_q      <= '0;
			mg_b_q      <= '0;
			ml_a_q      <= '0;
			ml_b_q      <= '0;
			res_q       <= '0;
			out_data_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			if (out_valid_q && out_req.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_NUM_DIMS: num_dims_q <= cfg_data[DIMS_W-1:0];
					CFG_SIZE0:    size_q[0]  <= cfg_data[SIZE_W-1:0];
					CFG_SIZE1:    size_q[1]  <= cfg_data[SIZE_W-1:0];
					CFG_SIZE2:    size_q[2]  <= cfg_data[SIZE_W-1:0];
					CFG_PROCS0:   procs_q[0] <= cfg_data[PROCS_W-1:0];
					CFG_PROCS1:   procs_q[1] <= cfg_data[PROCS_W-1:0];
					CFG_PROCS2:   procs_q[2] <= cfg_data[PROCS_W-1:0];
					CFG_NUM_VARS: num_vars_q <= cfg_data[VARS_W-1:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_req.data.kind == KIND_START) begin
							active_q <= 1'b0;
							var_q    <= '0;
							for (int d = 0; d < NDIM; d++) walk_q[d] <= '0;
							d_q      <= '0;
							div_n_q  <= in_req.data.rank;
							div_d_q  <= DIV_D_W'(procs_eff[0]);
							div_go_q <= 1'b1;
							state_q  <= S_RDIV;
						end else if (!active_q) begin
							res_q   <= '{global_address: '0, local_address: '0,
								last_word: 1'b0, status: ST_NO_BLOCK};
							state_q <= S_RES;
						end else begin
							h_q      <= 2'd2;
							mg_a_q   <= ADDR_W'(gsum[2]);
							mg_b_q   <= MUL_B_W'(size_eff[1]);
							ml_a_q   <= ADDR_W'(walk_q[2]);
							ml_b_q   <= MUL_B_W'(len_q[1]);
							mul_go_q <= 1'b1;
							state_q  <= S_HMUL;
						end
					end
				end
				S_RDIV: begin
					if (div_done) begin
						coord_q[d_q] <= div_rem[PROCS_W-1:0];
						if (d_q == 2'd2) begin
							if (div_quot != '0) begin
								res_q   <= '{global_address: '0, local_address: '0,
									last_word: 1'b0, status: ST_BAD_RANK};
								state_q <= S_RES;
							end else begin
								d_q      <= '0;
								empty_q  <= 1'b0;
								div_n_q  <= DIV_N_W'(size_eff[0]);
								div_d_q  <= DIV_D_W'(procs_eff[0]);
								div_go_q <= 1'b1;
								state_q  <= S_SDIV;
							end
						end else begin
							d_q      <= dn;
							div_n_q  <= div_quot;
							div_d_q  <= DIV_D_W'(procs_eff[dn]);
							div_go_q <= 1'b1;
						end
					end
				end
				S_SDIV: begin
					if (div_done) begin
						share_q  <= div_quot[SIZE_W-1:0];
						srem_q   <= div_rem;
						mg_a_q   <= ADDR_W'(coord_q[d_q]);
						mg_b_q   <= div_quot[MUL_B_W-1:0];
						ml_a_q   <= '0;
						ml_b_q   <= '0;
						mul_go_q <= 1'b1;
						state_q  <= S_SMUL;
					end
				end
				S_SMUL: begin
					if (mg_done) begin
						start_q[d_q] <= mg_prod[SIZE_W-1:0];
						len_q[d_q]   <= len_new;
						empty_q      <= empty_n;
						if (d_q == 2'd2) begin
							res_q    <= '{global_address: '0, local_address: '0,
								last_word: 1'b0, status: (empty_n ? ST_EMPTY : ST_OK)};
							active_q <= !empty_n;
							state_q  <= S_RES;
						end else begin
							d_q      <= dn;
							div_n_q  <= DIV_N_W'(size_eff[dn]);
							div_d_q  <= DIV_D_W'(procs_eff[dn]);
							div_go_q <= 1'b1;
							state_q  <= S_SDIV;
						end
					end
				end
				S_HMUL: begin
					if (mg_done && ml_done) begin
						if (h_q == 2'd0) begin
							res_q <= '{global_address: sum_g, local_address: sum_l,
								last_word: at_end, status: ST_OK};
							if ({1'b0, var_q} + 1'b1 < nv_eff) begin
								var_q <= var_q + 1'b1;
							end else begin
								var_q <= '0;
								if (inc[0]) begin
									walk_q[0] <= walk_q[0] + 1'b1;
								end else begin
									walk_q[0] <= '0;
									if (inc[1]) begin
										walk_q[1] <= walk_q[1] + 1'b1;
									end else begin
										walk_q[1] <= '0;
										if (inc[2]) walk_q[2] <= walk_q[2] + 1'b1;
										else walk_q[2] <= '0;
									end
								end
							end
							if (at_end) active_q <= 1'b0;
							state_q <= S_RES;
						end else begin
							h_q      <= h_q - 2'd1;
							mg_a_q   <= sum_g;
							mg_b_q   <= nmul_g;
							ml_a_q   <= sum_l;
							ml_b_q   <= nmul_l;
							mul_go_q <= 1'b1;
						end
					end
				end
				S_RES: begin
					if (!out_valid_q || out_req.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ sv/bdag_div.sv @@
// ----------------------------------------------------------------------------
// bdag_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bdag_div import bdag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quot,
	output logic [DIV_D_W-1:0] rem
);
	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] q_q;
	logic [DIV_D_W-1:0] r_q;
	logic [DIV_D_W-1:0] d_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic               fits;

	assign trial = {r_q, q_q[DIV_N_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else if (start) begin
			q_q    <= dividend;
			r_q    <= '0;
			d_q    <= divisor;
			cnt_q  <= CNT_W'(DIV_N_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (fits) begin
				r_q <= DIV_D_W'(trial - {1'b0, d_q});
			end else begin
				r_q <= trial[DIV_D_W-1:0];
			end
			q_q   <= {q_q[DIV_N_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule

@@ sv/bdag_mul.sv @@
// ----------------------------------------------------------------------------
// bdag_mul
// shift-add multiplier, one multiplier bit per cycle, product wraps
// ----------------------------------------------------------------------------
module bdag_mul import bdag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ADDR_W-1:0]  a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [ADDR_W-1:0]  prod
);
	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [ADDR_W-1:0]  a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [ADDR_W-1:0]  p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
		end else if (start) begin
			a_q    <= a;
			b_q    <= b;
			p_q    <= '0;
			cnt_q  <= CNT_W'(MUL_B_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			p_q   <= {p_q[ADDR_W-2:0], 1'b0} + (b_q[MUL_B_W-1] ? a_q : '0);
			b_q   <= {b_q[MUL_B_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign prod = p_q;
endmodule

@@ sv/bdag_checker.sv @@
// ----------------------------------------------------------------------------
// bdag_checker
// port-level checks of the address generator, bound to the top level
// ----------------------------------------------------------------------------
`include "block_decomposition_address_generator_unit_defines.svh"

module bdag_checker import bdag_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input out_req_t out_data
);
	// output valid held while stalled
	`BDAG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// busy after taking a request
	`BDAG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// no address and no last word on a non-ok result
	`BDAG_ASSERT_NOW(a_err_zero, out_valid && (out_data.status != ST_OK), (out_data.global_address == '0) && (out_data.local_address == '0) && !out_data.last_word)
	// last word only on a good word
	`BDAG_ASSERT_NOW(a_last_ok, out_valid && out_data.last_word, out_data.status == ST_OK)
endmodule

bind block_decomposition_address_generator_unit bdag_checker u_bdag_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_req.valid),
	.in_ready(in_req.ready),
	.out_valid(out_req.valid),
	.out_ready(out_req.ready),
	.out_data(out_req.data)
);
